[hw/rtl/bptc_pkg.sv]
package bptc_pkg;

  // Widths
  localparam int unsigned RAW_W   = 24;
  localparam int unsigned CFG_W   = 48;
  localparam int unsigned WORD_W  = 64;
  localparam int unsigned RF_AW   = 3;
  localparam int unsigned PC_W    = 7;
  localparam int unsigned IMM_W   = 6;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_TEMP_CALIB    = 2'd0;
  localparam logic [1:0] REG_PRESS_CALIB_A = 2'd1;
  localparam logic [1:0] REG_PRESS_CALIB_B = 2'd2;
  localparam logic [1:0] REG_PRESS_CALIB_C = 2'd3;

  // Micro-operations of the shared datapath
  typedef enum logic [3:0] {
    OP_LDK  = 4'd0,   // load coefficient, sample, stored temperature or constant
    OP_ADD  = 4'd1,
    OP_SUB  = 4'd2,
    OP_SHL  = 4'd3,   // left shift by imm
    OP_SDS  = 4'd4,   // signed divide by 2^imm, toward zero
    OP_LO40 = 4'd5,   // keep low 40 bits
    OP_MUL  = 4'd6,   // 64-bit wrapping multiply (multi-cycle)
    OP_DIV10= 4'd7,   // signed divide by ten (multi-cycle)
    OP_STT  = 4'd8,   // store linearized temperature
    OP_TOUT = 4'd9,   // emit temperature result
    OP_POUT = 4'd10   // emit pressure result
  } op_t;

  // Load selectors
  localparam logic [IMM_W-1:0] K_RAW   = 6'd0;
  localparam logic [IMM_W-1:0] K_T1    = 6'd1;
  localparam logic [IMM_W-1:0] K_T2    = 6'd2;
  localparam logic [IMM_W-1:0] K_T3    = 6'd3;
  localparam logic [IMM_W-1:0] K_P1    = 6'd4;
  localparam logic [IMM_W-1:0] K_P2    = 6'd5;
  localparam logic [IMM_W-1:0] K_P3    = 6'd6;
  localparam logic [IMM_W-1:0] K_P4    = 6'd7;
  localparam logic [IMM_W-1:0] K_P5    = 6'd8;
  localparam logic [IMM_W-1:0] K_P6    = 6'd9;
  localparam logic [IMM_W-1:0] K_P7    = 6'd10;
  localparam logic [IMM_W-1:0] K_P8    = 6'd11;
  localparam logic [IMM_W-1:0] K_P9    = 6'd12;
  localparam logic [IMM_W-1:0] K_P10   = 6'd13;
  localparam logic [IMM_W-1:0] K_P11   = 6'd14;
  localparam logic [IMM_W-1:0] K_LT    = 6'd15;
  localparam logic [IMM_W-1:0] K_25    = 6'd16;
  localparam logic [IMM_W-1:0] K_16384 = 6'd17;

  localparam logic [PC_W-1:0] T_START = 7'd0;
  localparam logic [PC_W-1:0] P_START = 7'd17;

  typedef struct packed {
    op_t              op;
    logic [RF_AW-1:0] dst;
    logic [RF_AW-1:0] a;
    logic [RF_AW-1:0] b;
    logic [IMM_W-1:0] imm;
  } instr_t;

  // Request to the multi-cycle unit
  typedef struct packed {
    logic start;
    logic div;
  } unit_req_t;

  function automatic instr_t mk(op_t op, logic [RF_AW-1:0] d, logic [RF_AW-1:0] a,
                                logic [RF_AW-1:0] b, logic [IMM_W-1:0] imm);
    instr_t i;
    i.op  = op;
    i.dst = d;
    i.a   = a;
    i.b   = b;
    i.imm = imm;
    return i;
  endfunction

  // Microcode: temperature program, then pressure program
  function automatic instr_t prog(logic [PC_W-1:0] pc);
    instr_t i;
    case (pc)
      // temperature
      7'd0:  i = mk(OP_LDK, 0, 0, 0, K_RAW);
      7'd1:  i = mk(OP_LDK, 1, 0, 0, K_T1);
      7'd2:  i = mk(OP_SHL, 1, 1, 0, 6'd8);
      7'd3:  i = mk(OP_SUB, 0, 0, 1, 6'd0);
      7'd4:  i = mk(OP_LDK, 1, 0, 0, K_T2);
      7'd5:  i = mk(OP_MUL, 1, 1, 0, 6'd0);
      7'd6:  i = mk(OP_MUL, 2, 0, 0, 6'd0);
      7'd7:  i = mk(OP_LDK, 3, 0, 0, K_T3);
      7'd8:  i = mk(OP_MUL, 2, 2, 3, 6'd0);
      7'd9:  i = mk(OP_SHL, 1, 1, 0, 6'd18);
      7'd10: i = mk(OP_ADD, 1, 1, 2, 6'd0);
      7'd11: i = mk(OP_SDS, 1, 1, 0, 6'd32);
      7'd12: i = mk(OP_STT, 0, 1, 0, 6'd0);
      7'd13: i = mk(OP_LDK, 2, 0, 0, K_25);
      7'd14: i = mk(OP_MUL, 1, 1, 2, 6'd0);
      7'd15: i = mk(OP_SDS, 1, 1, 0, 6'd14);
      7'd16: i = mk(OP_TOUT, 0, 1, 0, 6'd0);
      // pressure: square and cube of t
      7'd17: i = mk(OP_LDK, 0, 0, 0, K_LT);
      7'd18: i = mk(OP_MUL, 1, 0, 0, 6'd0);
      7'd19: i = mk(OP_SDS, 2, 1, 0, 6'd6);
      7'd20: i = mk(OP_MUL, 2, 2, 0, 6'd0);
      7'd21: i = mk(OP_SDS, 2, 2, 0, 6'd8);
      // offset
      7'd22: i = mk(OP_LDK, 3, 0, 0, K_P5);
      7'd23: i = mk(OP_SHL, 3, 3, 0, 6'd47);
      7'd24: i = mk(OP_LDK, 4, 0, 0, K_P8);
      7'd25: i = mk(OP_MUL, 4, 4, 2, 6'd0);
      7'd26: i = mk(OP_SDS, 4, 4, 0, 6'd5);
      7'd27: i = mk(OP_ADD, 3, 3, 4, 6'd0);
      7'd28: i = mk(OP_LDK, 4, 0, 0, K_P7);
      7'd29: i = mk(OP_MUL, 4, 4, 1, 6'd0);
      7'd30: i = mk(OP_SHL, 4, 4, 0, 6'd4);
      7'd31: i = mk(OP_ADD, 3, 3, 4, 6'd0);
      7'd32: i = mk(OP_LDK, 4, 0, 0, K_P6);
      7'd33: i = mk(OP_MUL, 4, 4, 0, 6'd0);
      7'd34: i = mk(OP_SHL, 4, 4, 0, 6'd22);
      7'd35: i = mk(OP_ADD, 3, 3, 4, 6'd0);
      7'd36: i = mk(OP_SDS, 3, 3, 0, 6'd2);
      // sensitivity
      7'd37: i = mk(OP_LDK, 4, 0, 0, K_P1);
      7'd38: i = mk(OP_LDK, 5, 0, 0, K_16384);
      7'd39: i = mk(OP_SUB, 4, 4, 5, 6'd0);
      7'd40: i = mk(OP_SHL, 4, 4, 0, 6'd46);
      7'd41: i = mk(OP_LDK, 5, 0, 0, K_P4);
      7'd42: i = mk(OP_MUL, 5, 5, 2, 6'd0);
      7'd43: i = mk(OP_SDS, 5, 5, 0, 6'd5);
      7'd44: i = mk(OP_ADD, 4, 4, 5, 6'd0);
      7'd45: i = mk(OP_LDK, 5, 0, 0, K_P3);
      7'd46: i = mk(OP_MUL, 5, 5, 1, 6'd0);
      7'd47: i = mk(OP_SHL, 5, 5, 0, 6'd2);
      7'd48: i = mk(OP_ADD, 4, 4, 5, 6'd0);
      7'd49: i = mk(OP_LDK, 5, 0, 0, K_P2);
      7'd50: i = mk(OP_LDK, 6, 0, 0, K_16384);
      7'd51: i = mk(OP_SUB, 5, 5, 6, 6'd0);
      7'd52: i = mk(OP_MUL, 5, 5, 0, 6'd0);
      7'd53: i = mk(OP_SHL, 5, 5, 0, 6'd21);
      7'd54: i = mk(OP_ADD, 4, 4, 5, 6'd0);
      // first term
      7'd55: i = mk(OP_SDS, 4, 4, 0, 6'd24);
      7'd56: i = mk(OP_LDK, 5, 0, 0, K_RAW);
      7'd57: i = mk(OP_MUL, 4, 4, 5, 6'd0);
      7'd58: i = mk(OP_ADD, 3, 3, 4, 6'd0);
      // second term
      7'd59: i = mk(OP_LDK, 4, 0, 0, K_P10);
      7'd60: i = mk(OP_MUL, 4, 4, 0, 6'd0);
      7'd61: i = mk(OP_LDK, 6, 0, 0, K_P9);
      7'd62: i = mk(OP_SHL, 6, 6, 0, 6'd16);
      7'd63: i = mk(OP_ADD, 4, 4, 6, 6'd0);
      7'd64: i = mk(OP_MUL, 4, 4, 5, 6'd0);
      7'd65: i = mk(OP_SDS, 4, 4, 0, 6'd13);
      7'd66: i = mk(OP_DIV10, 4, 4, 0, 6'd0);
      7'd67: i = mk(OP_MUL, 4, 5, 4, 6'd0);
      7'd68: i = mk(OP_SDS, 4, 4, 0, 6'd9);
      7'd69: i = mk(OP_SHL, 6, 4, 0, 6'd3);
      7'd70: i = mk(OP_SHL, 4, 4, 0, 6'd1);
      7'd71: i = mk(OP_ADD, 4, 4, 6, 6'd0);
      7'd72: i = mk(OP_ADD, 3, 3, 4, 6'd0);
      // third term
      7'd73: i = mk(OP_MUL, 4, 5, 5, 6'd0);
      7'd74: i = mk(OP_LDK, 6, 0, 0, K_P11);
      7'd75: i = mk(OP_MUL, 4, 6, 4, 6'd0);
      7'd76: i = mk(OP_SDS, 4, 4, 0, 6'd16);
      7'd77: i = mk(OP_MUL, 4, 4, 5, 6'd0);
      7'd78: i = mk(OP_SDS, 4, 4, 0, 6'd7);
      7'd79: i = mk(OP_ADD, 3, 3, 4, 6'd0);
      // scale by 25 / 2^40
      7'd80: i = mk(OP_SDS, 4, 3, 0, 6'd40);
      7'd81: i = mk(OP_LDK, 6, 0, 0, K_25);
      7'd82: i = mk(OP_MUL, 4, 4, 6, 6'd0);
      7'd83: i = mk(OP_LO40, 7, 3, 0, 6'd0);
      7'd84: i = mk(OP_MUL, 7, 7, 6, 6'd0);
      7'd85: i = mk(OP_SDS, 7, 7, 0, 6'd40);
      7'd86: i = mk(OP_ADD, 4, 4, 7, 6'd0);
      7'd87: i = mk(OP_POUT, 0, 4, 3, 6'd0);
      default: i = mk(OP_POUT, 0, 4, 3, 6'd0);
    endcase
    return i;
  endfunction

endpackage

[hw/rtl/baro_temp_press_compensation_core.sv]
// Channel  | Direction | Signals
// input    | in        | in_valid, in_stall, command, raw_sample
// output   | out       | out_valid, out_stall, kind, value
// config   | in        | cfg_write_en, cfg_index, cfg_data
//
// Micro-steps run on one 64-bit datapath with a shared 32x32 multiplier. A plain step
// passes through fetch and execute; products and the divide by ten (16-bit digits by
// reciprocal multiply) wait in the unit. Synchronous reset clears calibration, stored
// temperature, control. A waiting result does not block the next item; a new
// result waits for it to drain.
module baro_temp_press_compensation_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        command,
  input  logic [bptc_pkg::RAW_W-1:0]  raw_sample,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        kind,
  output logic signed [31:0]          value,
  input  logic                        cfg_write_en,
  input  logic [1:0]                  cfg_index,
  input  logic [bptc_pkg::CFG_W-1:0]  cfg_data
);
  import bptc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FETCH = 4'b0010,
    S_EXEC  = 4'b0100,
    S_WAIT  = 4'b1000
  } state_t;

  state_t            state;
  logic [PC_W-1:0]   pc;
  instr_t            ins;
  instr_t            ins_next;
  logic [RAW_W-1:0]  raw;
  logic [39:0]       temp_calib;
  logic [47:0]       press_calib_a;
  logic [47:0]       press_calib_b;
  logic [31:0]       press_calib_c;
  logic [WORD_W-1:0] linear_temp;
  logic [WORD_W-1:0] rf [2**RF_AW];
  logic [WORD_W-1:0] opa;
  logic [WORD_W-1:0] opb;
  logic [WORD_W-1:0] kval;
  logic [WORD_W-1:0] alu;
  logic [WORD_W-1:0] bias;
  logic [WORD_W-1:0] unit_res;
  logic              unit_busy;
  logic              unit_done;
  unit_req_t         req;
  logic              out_free;
  logic              out_load;
  logic [31:0]       tsat;
  logic [31:0]       psat;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign ins_next = prog(pc);
  assign out_load = (state == S_EXEC) && (ins.op == OP_TOUT || ins.op == OP_POUT) && out_free;

  // Coefficient and constant selection
  always_comb begin
    case (ins.imm)
      K_RAW:   kval = {40'd0, raw};
      K_T1:    kval = {48'd0, temp_calib[15:0]};
      K_T2:    kval = {48'd0, temp_calib[31:16]};
      K_T3:    kval = {{56{temp_calib[39]}}, temp_calib[39:32]};
      K_P1:    kval = {{48{press_calib_a[15]}}, press_calib_a[15:0]};
      K_P2:    kval = {{48{press_calib_a[31]}}, press_calib_a[31:16]};
      K_P3:    kval = {{56{press_calib_a[39]}}, press_calib_a[39:32]};
      K_P4:    kval = {{56{press_calib_a[47]}}, press_calib_a[47:40]};
      K_P5:    kval = {48'd0, press_calib_b[15:0]};
      K_P6:    kval = {48'd0, press_calib_b[31:16]};
      K_P7:    kval = {{56{press_calib_b[39]}}, press_calib_b[39:32]};
      K_P8:    kval = {{56{press_calib_b[47]}}, press_calib_b[47:40]};
      K_P9:    kval = {{48{press_calib_c[15]}}, press_calib_c[15:0]};
      K_P10:   kval = {{56{press_calib_c[23]}}, press_calib_c[23:16]};
      K_P11:   kval = {{56{press_calib_c[31]}}, press_calib_c[31:24]};
      K_LT:    kval = linear_temp;
      K_25:    kval = WORD_W'(25);
      K_16384: kval = WORD_W'(16384);
      default: kval = '0;
    endcase
  end

  // Combinational datapath ops
  always_comb begin
    bias = opa[63] ? ((WORD_W'(1) << ins.imm) - WORD_W'(1)) : '0;
    case (ins.op)
      OP_LDK:  alu = kval;
      OP_ADD:  alu = opa + opb;
      OP_SUB:  alu = opa - opb;
      OP_SHL:  alu = opa << ins.imm;
      OP_SDS:  alu = WORD_W'($signed(opa + bias) >>> ins.imm);
      OP_LO40: alu = {24'd0, opa[39:0]};
      default: alu = opa;
    endcase
  end

  // Output saturation
  always_comb begin
    if (opa[63:31] == {33{opa[63]}}) tsat = opa[31:0];
    else tsat = opa[63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    if (opb[63]) psat = '0;
    else if (opa > WORD_W'(32'h7FFF_FFFF)) psat = 32'h7FFF_FFFF;
    else psat = opa[31:0];
  end

  assign req.start = (state == S_EXEC) && (ins.op == OP_MUL || ins.op == OP_DIV10);
  assign req.div   = (ins.op == OP_DIV10);

  bptc_unit u_unit (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .a      (opa),
    .b      (opb),
    .busy   (unit_busy),
    .done   (unit_done),
    .result (unit_res)
  );

  // Register file
  always_ff @(posedge clk) begin
    if (state == S_FETCH) begin
      opa <= rf[ins_next.a];
      opb <= rf[ins_next.b];
    end
    if (state == S_EXEC && (ins.op == OP_LDK || ins.op == OP_ADD || ins.op == OP_SUB ||
        ins.op == OP_SHL || ins.op == OP_SDS || ins.op == OP_LO40)) begin
      rf[ins.dst] <= alu;
    end else if (state == S_WAIT && unit_done) begin
      rf[ins.dst] <= unit_res;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      temp_calib    <= '0;
      press_calib_a <= '0;
      press_calib_b <= '0;
      press_calib_c <= '0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_TEMP_CALIB:    temp_calib    <= cfg_data[39:0];
        REG_PRESS_CALIB_A: press_calib_a <= cfg_data;
        REG_PRESS_CALIB_B: press_calib_b <= cfg_data;
        REG_PRESS_CALIB_C: press_calib_c <= cfg_data[31:0];
        default: begin end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
      kind      <= (ins.op == OP_POUT);
      value     <= (ins.op == OP_POUT) ? psat : tsat;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      pc          <= '0;
      linear_temp <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            raw   <= raw_sample;
            pc    <= command ? P_START : T_START;
            state <= S_FETCH;
          end
        end
        S_FETCH: begin
          ins   <= ins_next;
          state <= S_EXEC;
        end
        S_EXEC: begin
          case (ins.op)
            OP_MUL, OP_DIV10: state <= S_WAIT;
            OP_TOUT, OP_POUT: begin
              if (out_free) state <= S_IDLE;
            end
            default: begin
              if (ins.op == OP_STT) linear_temp <= opa;
              pc    <= pc + PC_W'(1);
              state <= S_FETCH;
            end
          endcase
        end
        S_WAIT: begin
          if (unit_done) begin
            pc    <= pc + PC_W'(1);
            state <= S_FETCH;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  a_accept_fetch: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state == S_FETCH) else $error("accept did not start program");
  a_unit_wait: assert property (@(posedge clk) disable iff (rst)
    unit_busy |-> state == S_WAIT) else $error("unit busy outside wait");
  a_out_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_EXEC)) else $error("result not from exec");
  a_done_wait: assert property (@(posedge clk) disable iff (rst)
    unit_done |-> state == S_WAIT) else $error("unit done outside wait");

endmodule

[hw/rtl/bptc_unit.sv]
module bptc_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  bptc_pkg::unit_req_t        req,
  input  logic [bptc_pkg::WORD_W-1:0] a,
  input  logic [bptc_pkg::WORD_W-1:0] b,
  output logic                       busy,
  output logic                       done,
  output logic [bptc_pkg::WORD_W-1:0] result
);
  import bptc_pkg::*;

  logic              div;
  logic [6:0]        cnt;
  logic [WORD_W-1:0] x;
  logic [WORD_W-1:0] y;
  logic [WORD_W-1:0] lo;
  logic [31:0]       hi;
  logic [31:0]       mx;
  logic [31:0]       my;
  logic [63:0]       m;
  logic              neg;
  logic [3:0]        rem;
  logic [19:0]       dv;
  logic [15:0]       qd;
  logic [19:0]       rdiff;

  // Shared 32x32 multiplier, operand halves chosen by step.
  // Divide by ten: partial dividend times 2^23/10 rounded up, exact below 10 * 2^16.
  always_comb begin
    dv = {rem, x[63:48]};
    mx = x[31:0];
    my = y[31:0];
    if (div) begin
      mx = {12'd0, dv};
      my = 32'd838861;
    end else begin
      case (cnt[1:0])
        2'd1:    my = y[63:32];
        2'd2:    mx = x[63:32];
        default: begin end
      endcase
    end
    m = mx * my;
  end

  // One 16-bit quotient digit per cycle for divide by ten
  assign qd    = m[38:23];
  assign rdiff = dv - ({1'b0, qd, 3'd0} + {3'd0, qd, 1'b0});

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      div  <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      div  <= req.div;
      cnt  <= '0;
      neg  <= a[63];
      x    <= (req.div && a[63]) ? (WORD_W'(0) - a) : a;
      y    <= b;
      rem  <= '0;
    end else if (busy) begin
      cnt <= cnt + 7'd1;
      if (div) begin
        if (cnt == 7'd4) begin
          result <= neg ? (WORD_W'(0) - x) : x;
          busy   <= 1'b0;
          done   <= 1'b1;
        end else begin
          x   <= {x[47:0], qd};
          rem <= rdiff[3:0];
        end
      end else begin
        case (cnt[1:0])
          2'd0:    lo <= m;
          2'd1:    hi <= m[31:0];
          2'd2:    hi <= hi + m[31:0];
          default: begin
            result <= lo + {hi, 32'd0};
            busy   <= 1'b0;
            done   <= 1'b1;
          end
        endcase
      end
    end
  end

endmodule
